[rtl/pid_pkg.sv]
// ----------------------------------------------------------------------------
// pid_pkg: shared types, constants and helpers of the personal ID validator
// Widths, cause codes, pipeline stage records, the double-dabble step, the
// month length table, the leap-year rule and the modulo-11 reduction.
// ----------------------------------------------------------------------------
package pid_pkg;

    localparam int ID_W           = 44;
    localparam int DIG_N          = 14;              // one digit above the 13 used
    localparam int DIG_W          = 4 * DIG_N;
    localparam int BITS_PER_STAGE = 4;
    localparam int DD_STAGES      = ID_W / BITS_PER_STAGE;
    localparam int SUM_W          = 9;               // weighted sum stays below 512
    localparam int CAUSE_W        = 3;
    localparam int DAY_W          = 7;
    localparam int YEAR_W         = 12;
    localparam int SERIAL_W       = 10;
    localparam int MOD_M          = 11;

    localparam logic [CAUSE_W-1:0] CAUSE_OK       = 3'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_RANGE    = 3'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_DATE     = 3'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_CHECK_TEN = 3'd3;
    localparam logic [CAUSE_W-1:0] CAUSE_MISMATCH = 3'd4;

    localparam logic [SERIAL_W-1:0] FEMALE_FROM = 10'd500;
    localparam logic [DAY_W-1:0]    MONTH_FEB   = 7'd2;
    localparam logic [DAY_W-1:0]    MONTH_LAST  = 7'd12;

    typedef struct packed {
        logic [DIG_W-1:0] bcd;
        logic [ID_W-1:0]  bin;
    } t_dd;

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [DAY_W-1:0]    month;
        logic [YEAR_W-1:0]   year;
        logic [DAY_W-1:0]    region;
        logic [SERIAL_W-1:0] serial;
        logic [SUM_W-1:0]    sum;
        logic [3:0]          check;
        logic                over;
        logic                leap;
    } t_dec;

    typedef struct packed {
        logic                is_valid;
        logic [CAUSE_W-1:0]  fail_cause;
        logic [DAY_W-1:0]    birth_day;
        logic [DAY_W-1:0]    birth_month;
        logic [YEAR_W-1:0]   birth_year;
        logic [DAY_W-1:0]    region_code;
        logic [SERIAL_W-1:0] serial_code;
        logic                is_female;
    } t_res;

    // Several shift-and-add-3 iterations: adjust every BCD column, then shift in one bit
    function automatic t_dd dd_step(input t_dd a);
        t_dd r;
        r = a;
        for (int it = 0; it < BITS_PER_STAGE; it++) begin
            for (int c = 0; c < DIG_N; c++) begin
                if (r.bcd[c*4 +: 4] >= 4'd5) begin
                    r.bcd[c*4 +: 4] = r.bcd[c*4 +: 4] + 4'd3;
                end
            end
            r = t_dd'({r.bcd, r.bin} << 1);
        end
        return r;
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] d;
        case (m)
            4'd1:    d = 5'd31;
            4'd2:    d = 5'd28;
            4'd3:    d = 5'd31;
            4'd4:    d = 5'd30;
            4'd5:    d = 5'd31;
            4'd6:    d = 5'd30;
            4'd7:    d = 5'd31;
            4'd8:    d = 5'd31;
            4'd9:    d = 5'd30;
            4'd10:   d = 5'd31;
            4'd11:   d = 5'd30;
            4'd12:   d = 5'd31;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    // Leap rule from digits: yy = last two year digits, hund = hundreds digit of the year.
    // Centuries 20, 12 and 16 are divisible by four, hence by 400 as years.
    function automatic logic leap_from_digits(input logic [3:0] hund, input logic [6:0] yy);
        logic cent_ok;
        cent_ok = (hund == 4'd0) || (hund == 4'd2) || (hund == 4'd6);
        return (yy != 7'd0) ? (yy[1:0] == 2'b00) : cent_ok;
    endfunction

    // Remainder by eleven through a short compare-and-subtract ladder
    function automatic logic [3:0] mod11(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = s;
        for (int k = 5; k >= 0; k--) begin
            if (r >= SUM_W'(MOD_M << k)) begin
                r = r - SUM_W'(MOD_M << k);
            end
        end
        return r[3:0];
    endfunction

endpackage

[rtl/pid_if.sv]
// ----------------------------------------------------------------------------
// pid_if: transfer channels of the personal ID validator
// Input channel carries the identity number, output channel the check result.
// ----------------------------------------------------------------------------
interface pid_in_if;
    logic        valid;
    logic        ready;
    logic [43:0] id_number;

    modport source (output valid, output id_number, input ready);
    modport sink   (input valid, input id_number, output ready);
endinterface

interface pid_out_if;
    logic        valid;
    logic        ready;
    logic        is_valid;
    logic [2:0]  fail_cause;
    logic [6:0]  birth_day;
    logic [6:0]  birth_month;
    logic [11:0] birth_year;
    logic [6:0]  region_code;
    logic [9:0]  serial_code;
    logic        is_female;

    modport source (output valid, output is_valid, output fail_cause, output birth_day,
                    output birth_month, output birth_year, output region_code,
                    output serial_code, output is_female, input ready);
    modport sink   (input valid, input is_valid, input fail_cause, input birth_day,
                    input birth_month, input birth_year, input region_code,
                    input serial_code, input is_female, output ready);
endinterface

[rtl/personal_id_validator_top.sv]
// ----------------------------------------------------------------------------
// personal_id_validator_top: identity number check with date and mod-11 digit
// Splits a 44-bit number into decimal digits, decodes the personal fields,
// checks the calendar date and the weighted check digit.
// ----------------------------------------------------------------------------
// Usage:
//   i_id  : input channel, one identity number per transfer (valid/ready).
//   o_res : output channel, one result per accepted number, in order.
//   Pipeline: each input transfer is first captured in an input register.
//     The binary to decimal conversion that follows is an 11-stage
//     shift-and-add-3 pipeline (four bits per stage), followed by a decode
//     stage and the result register.
//   Throughput: one number per cycle while o_res.ready is high.
//   Stall: all stages advance together; while a result waits on o_res with
//     ready low, the whole pipeline holds and i_id.ready is low. Empty slots
//     hold with the rest, so a bubble in front of a stalled result stays put.
//   Reset: synchronous, active low; clears every stage valid, so no result
//     is offered after reset. There is no configuration and no stored state
//     beyond the pipeline.
// ----------------------------------------------------------------------------
module personal_id_validator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pid_in_if.sink     i_id,
    pid_out_if.source  o_res
);
    import pid_pkg::*;

    logic                 w_en;
    logic [DD_STAGES:0]   r_vld;
    t_dd                  r_dd [DD_STAGES+1];
    t_dd                  n_dd [DD_STAGES+1];
    logic                 r_dec_vld;
    t_dec                 r_dec;
    t_dec                 n_dec;
    logic                 r_out_vld;
    t_res                 r_out;
    t_res                 n_out;

    // advance everything when the result register is free or being emptied
    assign w_en       = !r_out_vld || o_res.ready;
    assign i_id.ready = w_en;

    always_comb begin
        n_dd[0].bcd = '0;
        n_dd[0].bin = i_id.id_number;
        for (int j = 1; j <= DD_STAGES; j++) begin
            n_dd[j] = dd_step(r_dd[j-1]);
        end
    end

    // decode stage
    always_comb begin
        logic [3:0] d [13];
        logic [4:0] p [6];
        for (int i = 0; i < 13; i++) begin
            d[i] = r_dd[DD_STAGES].bcd[(12-i)*4 +: 4];
        end
        for (int i = 0; i < 6; i++) begin
            p[i] = {1'b0, d[i]} + {1'b0, d[i+6]};
        end
        n_dec.day    = DAY_W'(d[0]) * 7'd10 + DAY_W'(d[1]);
        n_dec.month  = DAY_W'(d[2]) * 7'd10 + DAY_W'(d[3]);
        n_dec.region = DAY_W'(d[7]) * 7'd10 + DAY_W'(d[8]);
        n_dec.serial = SERIAL_W'(d[9]) * 10'd100 + SERIAL_W'(d[10]) * 10'd10
                     + SERIAL_W'(d[11]);
        if (d[4] == 4'd0) begin
            n_dec.year = 12'd2000 + YEAR_W'(d[5]) * 12'd10 + YEAR_W'(d[6]);
        end else begin
            n_dec.year = 12'd1000 + YEAR_W'(d[4]) * 12'd100 + YEAR_W'(d[5]) * 12'd10
                       + YEAR_W'(d[6]);
        end
        n_dec.leap  = leap_from_digits(d[4], DAY_W'(d[5]) * 7'd10 + DAY_W'(d[6]));
        n_dec.sum   = SUM_W'(p[0]) * 9'd7 + SUM_W'(p[1]) * 9'd6 + SUM_W'(p[2]) * 9'd5
                    + SUM_W'(p[3]) * 9'd4 + SUM_W'(p[4]) * 9'd3 + SUM_W'(p[5]) * 9'd2;
        n_dec.check = d[12];
        n_dec.over  = (r_dd[DD_STAGES].bcd[DIG_W-1 -: 4] != 4'd0);
    end

    // check stage
    always_comb begin
        logic [3:0] rem;
        logic [3:0] k;
        logic [4:0] lim;
        logic       date_ok;
        rem = mod11(r_dec.sum);
        k   = (rem == 4'd0) ? 4'd0 : 4'(MOD_M) - rem;
        lim = month_days(r_dec.month[3:0]);
        if (r_dec.month == MONTH_FEB && r_dec.leap) begin
            lim = 5'd29;
        end
        date_ok = (r_dec.month >= 7'd1) && (r_dec.month <= MONTH_LAST)
               && (r_dec.day >= 7'd1) && (r_dec.day <= DAY_W'(lim));
        if (r_dec.over) begin
            n_out.fail_cause = CAUSE_RANGE;
        end else if (!date_ok) begin
            n_out.fail_cause = CAUSE_DATE;
        end else if (rem == 4'd1) begin
            n_out.fail_cause = CAUSE_CHECK_TEN;
        end else if (r_dec.check != k) begin
            n_out.fail_cause = CAUSE_MISMATCH;
        end else begin
            n_out.fail_cause = CAUSE_OK;
        end
        n_out.is_valid    = (n_out.fail_cause == CAUSE_OK);
        n_out.birth_day   = r_dec.day;
        n_out.birth_month = r_dec.month;
        n_out.birth_year  = r_dec.year;
        n_out.region_code = r_dec.region;
        n_out.serial_code = r_dec.serial;
        n_out.is_female   = (r_dec.serial >= FEMALE_FROM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_dec_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[DD_STAGES-1:0], i_id.valid};
            r_dec_vld <= r_vld[DD_STAGES];
            r_out_vld <= r_dec_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j <= DD_STAGES; j++) begin
                r_dd[j] <= n_dd[j];
            end
            r_dec <= n_dec;
            r_out <= n_out;
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.is_valid    = r_out.is_valid;
    assign o_res.fail_cause  = r_out.fail_cause;
    assign o_res.birth_day   = r_out.birth_day;
    assign o_res.birth_month = r_out.birth_month;
    assign o_res.birth_year  = r_out.birth_year;
    assign o_res.region_code = r_out.region_code;
    assign o_res.serial_code = r_out.serial_code;
    assign o_res.is_female   = r_out.is_female;

    a_valid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.is_valid == (o_res.fail_cause == CAUSE_OK)))
        else $error("is_valid disagrees with fail_cause");

    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.is_valid) |->
            (o_res.birth_month >= 7'd1 && o_res.birth_month <= MONTH_LAST
             && o_res.birth_day >= 7'd1 && o_res.birth_day <= 7'd31))
        else $error("accepted number carries an impossible date");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_id.ready)
        else $error("input taken while the result is stalled");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_res.valid)
        else $error("result offered straight after reset");

endmodule
